// File: hdl/tehs_pkg.sv
// ---------------------------------------------------------------------------
// tehs_pkg
// Shared types, constants and helpers for the timed event min-heap scheduler.
// ---------------------------------------------------------------------------
package tehs_pkg;

    localparam int MAX_EVENTS_DEF = 32;
    localparam int NUM_IDS        = 32;
    localparam int ID_W           = 5;
    localparam int TIME_W         = 64;
    localparam int AMT_W          = 31;

    localparam logic [1:0] OP_SCHED  = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_ADV    = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [TIME_W-1:0] TIME_NONE = {TIME_W{1'b1}};
    localparam logic [AMT_W-1:0]  CYC_MAX   = {AMT_W{1'b1}};

    // one heap slot: event number and its deadline
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] key;
    } ent_t;

    // now plus amount, saturating at all ones
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [AMT_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-AMT_W+1){1'b0}}, b};
        return s[TIME_W] ? TIME_NONE : s[TIME_W-1:0];
    endfunction

    // cycles until the next deadline, 0 if due, saturated
    function automatic logic [AMT_W-1:0] cyc_to(input logic any,
                                                input logic [TIME_W-1:0] nt,
                                                input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] d;
        d = nt - now;
        if (!any)
            return CYC_MAX;
        else if (nt <= now)
            return '0;
        else if (d < {{(TIME_W-AMT_W){1'b0}}, CYC_MAX})
            return d[AMT_W-1:0];
        else
            return CYC_MAX;
    endfunction

endpackage

// File: hdl/timed_event_min_heap_scheduler.sv
// Requests are served one at a time: a new request is taken only while the sequencer is idle,
// and an advance returns one result per fired event, each once the prior result is taken.
// Removal of a pending event and each insertion sift through the heap RAM level by level.
// Idle again in the cycle after the last result is taken.
// Reset: asynchronous, active low; time, count and pending bits clear, RAMs need no clearing.
// ---------------------------------------------------------------------------
// timed_event_min_heap_scheduler
// Event queue on a binary min-heap held in RAM, with a sequencer that sifts.
// ---------------------------------------------------------------------------
module timed_event_min_heap_scheduler #(
    parameter int MAX_EVENTS = tehs_pkg::MAX_EVENTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [tehs_pkg::ID_W-1:0]   event_id,
    input  logic [tehs_pkg::AMT_W-1:0]  amount,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        fired_valid,
    output logic [tehs_pkg::ID_W-1:0]   fired_event,
    output logic [tehs_pkg::TIME_W-1:0] fired_time,
    output logic                        last,
    output logic [tehs_pkg::TIME_W-1:0] next_time,
    output logic [tehs_pkg::AMT_W-1:0]  cycles_to_next,
    output logic [tehs_pkg::TIME_W-1:0] current_time
);
    import tehs_pkg::*;

    localparam int PW = $clog2(MAX_EVENTS);
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int XW = PW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TPOS  = 4'd1;
    localparam logic [3:0] S_RM    = 4'd2;
    localparam logic [3:0] S_RML   = 4'd3;
    localparam logic [3:0] S_UPST  = 4'd4;
    localparam logic [3:0] S_SUP   = 4'd5;
    localparam logic [3:0] S_SDL   = 4'd6;
    localparam logic [3:0] S_SDR   = 4'd7;
    localparam logic [3:0] S_SDC   = 4'd8;
    localparam logic [3:0] S_PLACE = 4'd9;
    localparam logic [3:0] S_INS   = 4'd10;
    localparam logic [3:0] S_ROOTR = 4'd11;
    localparam logic [3:0] S_OUTL  = 4'd12;
    localparam logic [3:0] S_AREAD = 4'd13;
    localparam logic [3:0] S_ACHK  = 4'd14;
    localparam logic [3:0] S_OWAIT = 4'd15;

    // control and datapath registers
    logic [3:0]          state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [TIME_W-1:0]   tgt_reg, tgt_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NUM_IDS-1:0]  pend_reg, pend_next;
    logic [PW-1:0]       i_reg, i_next;
    ent_t                cur_reg, cur_next;
    ent_t                ch_reg, ch_next;
    logic                sl_reg, sl_next;
    logic                rv_reg, rv_next;
    logic                rf_reg, rf_next;
    logic                ins_reg, ins_next;
    logic                hf_reg, hf_next;
    logic                cont_reg, cont_next;
    logic [ID_W-1:0]     fev_reg, fev_next;
    logic [TIME_W-1:0]   fdl_reg, fdl_next;

    // result register
    logic                ov_reg, ov_next;
    logic                ofv_reg, ofv_next;
    logic [ID_W-1:0]     ofe_reg, ofe_next;
    logic [TIME_W-1:0]   oft_reg, oft_next;
    logic                olast_reg, olast_next;
    logic [TIME_W-1:0]   ont_reg, ont_next;
    logic [AMT_W-1:0]    ocyc_reg, ocyc_next;
    logic [TIME_W-1:0]   onow_reg, onow_next;

    // RAM ports
    logic                h_we, h_re;
    logic [PW-1:0]       h_waddr, h_raddr;
    ent_t                h_wdata, h_rdata;
    logic                p_we, p_re;
    logic [ID_W-1:0]     p_waddr, p_raddr;
    logic [PW-1:0]       p_wdata, p_rdata;

    // index arithmetic
    logic [CW-1:0]       cnt_m1;
    logic [PW-1:0]       par_idx;
    logic [XW-1:0]       l_idx, r_idx, cnt_x;
    logic                in_acc, more, post_sel;
    logic [3:0]          post_state;

    tehs_ram #(.DEPTH(MAX_EVENTS), .W($bits(ent_t))) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    tehs_ram #(.DEPTH(NUM_IDS), .W(PW)) u_pos (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cnt_m1   = cnt_reg - CW'(1);
    assign par_idx  = PW'((i_reg - PW'(1)) >> 1);
    assign l_idx    = {1'b0, i_reg, 1'b1};
    assign r_idx    = l_idx + XW'(1);
    assign cnt_x    = XW'(cnt_reg);
    assign more     = (cnt_reg != '0) && (h_rdata.key <= tgt_reg);

    // where to go once a removal or placement has finished
    assign post_sel   = (op_reg == OP_SCHED) && !ins_reg;
    assign post_state = post_sel ? S_INS : ((op_reg == OP_ADV) ? S_AREAD : S_ROOTR);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        amt_next   = amt_reg;
        tgt_next   = tgt_reg;
        now_next   = now_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        ch_next    = ch_reg;
        sl_next    = sl_reg;
        rv_next    = rv_reg;
        rf_next    = rf_reg;
        ins_next   = ins_reg;
        hf_next    = hf_reg;
        cont_next  = cont_reg;
        fev_next   = fev_reg;
        fdl_next   = fdl_reg;
        ov_next    = ov_reg;
        ofv_next   = ofv_reg;
        ofe_next   = ofe_reg;
        oft_next   = oft_reg;
        olast_next = olast_reg;
        ont_next   = ont_reg;
        ocyc_next  = ocyc_reg;
        onow_next  = onow_reg;
        h_we       = 1'b0;
        h_waddr    = i_reg;
        h_wdata    = cur_reg;
        h_re       = 1'b0;
        h_raddr    = '0;
        p_we       = 1'b0;
        p_waddr    = cur_reg.id;
        p_wdata    = i_reg;
        p_re       = 1'b0;
        p_raddr    = id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = operation;
                    id_next  = event_id;
                    amt_next = amount;
                    ins_next = 1'b0;
                    hf_next  = 1'b0;
                    tgt_next = sat_add(now_reg, amount);
                    unique case (operation)
                        OP_SCHED, OP_CANCEL:
                        begin
                            if (pend_reg[event_id])
                            begin
                                p_re       = 1'b1;
                                p_raddr    = event_id;
                                state_next = S_TPOS;
                            end
                            else
                            begin
                                state_next = (operation == OP_SCHED) ? S_INS : S_ROOTR;
                            end
                        end
                        OP_CLEAR:
                        begin
                            pend_next  = '0;
                            cnt_next   = '0;
                            now_next   = '0;
                            state_next = S_ROOTR;
                        end
                        default:
                        begin
                            h_re       = 1'b1;
                            h_raddr    = '0;
                            state_next = S_ACHK;
                        end
                    endcase
                end
            end
            S_TPOS:
            begin
                pend_next[id_reg] = 1'b0;
                i_next            = p_rdata;
                state_next        = S_RM;
            end
            S_RM:
            begin
                // detach the last entry; done if the freed slot is the last
                cnt_next = cnt_m1;
                if (CW'(i_reg) == cnt_m1)
                begin
                    state_next = post_state;
                end
                else
                begin
                    h_re       = 1'b1;
                    h_raddr    = PW'(cnt_m1);
                    state_next = S_RML;
                end
            end
            S_RML:
            begin
                cur_next   = h_rdata;
                rf_next    = 1'b1;
                state_next = S_UPST;
            end
            S_UPST:
            begin
                if (i_reg == '0)
                begin
                    state_next = rf_reg ? S_SDL : S_PLACE;
                end
                else
                begin
                    h_re       = 1'b1;
                    h_raddr    = par_idx;
                    state_next = S_SUP;
                end
            end
            S_SUP:
            begin
                // h_rdata holds the parent
                if (cur_reg.key < h_rdata.key)
                begin
                    h_we       = 1'b1;
                    h_waddr    = i_reg;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = h_rdata.id;
                    p_wdata    = i_reg;
                    i_next     = par_idx;
                    rf_next    = 1'b0;
                    state_next = S_UPST;
                end
                else
                begin
                    state_next = rf_reg ? S_SDL : S_PLACE;
                end
            end
            S_SDL:
            begin
                if (l_idx < cnt_x)
                begin
                    h_re       = 1'b1;
                    h_raddr    = PW'(l_idx);
                    state_next = S_SDR;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SDR:
            begin
                ch_next = h_rdata;
                sl_next = h_rdata.key < cur_reg.key;
                rv_next = r_idx < cnt_x;
                if (r_idx < cnt_x)
                begin
                    h_re    = 1'b1;
                    h_raddr = PW'(r_idx);
                end
                state_next = S_SDC;
            end
            S_SDC:
            begin
                // pick the smaller child, left wins ties
                if (rv_reg && (h_rdata.key < (sl_reg ? ch_reg.key : cur_reg.key)))
                begin
                    h_we       = 1'b1;
                    h_waddr    = i_reg;
                    h_wdata    = h_rdata;
                    p_we       = 1'b1;
                    p_waddr    = h_rdata.id;
                    p_wdata    = i_reg;
                    i_next     = PW'(r_idx);
                    state_next = S_SDL;
                end
                else if (sl_reg)
                begin
                    h_we       = 1'b1;
                    h_waddr    = i_reg;
                    h_wdata    = ch_reg;
                    p_we       = 1'b1;
                    p_waddr    = ch_reg.id;
                    p_wdata    = i_reg;
                    i_next     = PW'(l_idx);
                    state_next = S_SDL;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                h_we       = 1'b1;
                h_waddr    = i_reg;
                h_wdata    = cur_reg;
                p_we       = 1'b1;
                p_waddr    = cur_reg.id;
                p_wdata    = i_reg;
                state_next = post_state;
            end
            S_INS:
            begin
                ins_next = 1'b1;
                if (cnt_reg < CW'(MAX_EVENTS))
                begin
                    cur_next.id       = id_reg;
                    cur_next.key      = sat_add(now_reg, amt_reg);
                    pend_next[id_reg] = 1'b1;
                    i_next            = PW'(cnt_reg);
                    cnt_next          = cnt_reg + CW'(1);
                    rf_next           = 1'b0;
                    state_next        = S_UPST;
                end
                else
                begin
                    state_next = S_ROOTR;
                end
            end
            S_ROOTR:
            begin
                h_re       = 1'b1;
                h_raddr    = '0;
                state_next = S_OUTL;
            end
            S_OUTL:
            begin
                ov_next    = 1'b1;
                ofv_next   = 1'b0;
                ofe_next   = '0;
                oft_next   = '0;
                olast_next = 1'b1;
                ont_next   = (cnt_reg != '0) ? h_rdata.key : TIME_NONE;
                ocyc_next  = cyc_to(cnt_reg != '0, h_rdata.key, now_reg);
                onow_next  = now_reg;
                cont_next  = 1'b0;
                state_next = S_OWAIT;
            end
            S_AREAD:
            begin
                h_re       = 1'b1;
                h_raddr    = '0;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (hf_reg || !more)
                begin
                    // report the previous firing, or the empty advance
                    ov_next    = 1'b1;
                    ofv_next   = hf_reg;
                    ofe_next   = hf_reg ? fev_reg : '0;
                    oft_next   = hf_reg ? fdl_reg : '0;
                    olast_next = !more;
                    ont_next   = (cnt_reg != '0) ? h_rdata.key : TIME_NONE;
                    ocyc_next  = cyc_to(cnt_reg != '0, h_rdata.key,
                                        more ? now_reg : tgt_reg);
                    onow_next  = more ? now_reg : tgt_reg;
                    if (!more)
                    begin
                        now_next = tgt_reg;
                    end
                    cont_next  = more;
                    state_next = S_OWAIT;
                end
                else
                begin
                    state_next = S_OWAIT;
                    cont_next  = 1'b1;
                end
            end
            default:
            begin
                // S_OWAIT: hold the result, then fire the root if more are due
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b0;
                    if (cont_reg)
                    begin
                        fev_next           = h_rdata.id;
                        fdl_next           = h_rdata.key;
                        now_next           = h_rdata.key;
                        pend_next[h_rdata.id] = 1'b0;
                        hf_next            = 1'b1;
                        i_next             = '0;
                        state_next         = S_RM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
            ov_reg    <= 1'b0;
            hf_reg    <= 1'b0;
            cont_reg  <= 1'b0;
            ins_reg   <= 1'b0;
            rf_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            hf_reg    <= hf_next;
            cont_reg  <= cont_next;
            ins_reg   <= ins_next;
            rf_reg    <= rf_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        amt_reg   <= amt_next;
        tgt_reg   <= tgt_next;
        i_reg     <= i_next;
        cur_reg   <= cur_next;
        ch_reg    <= ch_next;
        sl_reg    <= sl_next;
        rv_reg    <= rv_next;
        fev_reg   <= fev_next;
        fdl_reg   <= fdl_next;
        ofv_reg   <= ofv_next;
        ofe_reg   <= ofe_next;
        oft_reg   <= oft_next;
        olast_reg <= olast_next;
        ont_reg   <= ont_next;
        ocyc_reg  <= ocyc_next;
        onow_reg  <= onow_next;
    end

    assign out_valid      = ov_reg;
    assign fired_valid    = ofv_reg;
    assign fired_event    = ofe_reg;
    assign fired_time     = oft_reg;
    assign last           = olast_reg;
    assign next_time      = ont_reg;
    assign cycles_to_next = ocyc_reg;
    assign current_time   = onow_reg;

endmodule

// File: hdl/tehs_ram.sv
// ---------------------------------------------------------------------------
// tehs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module tehs_ram #(
    parameter int DEPTH = 32,
    parameter int W     = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tehs_checker.sv
// ---------------------------------------------------------------------------
// tehs_checker
// Port-level checks on the scheduler's request and result channels.
// ---------------------------------------------------------------------------
module tehs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        fired_valid,
    input logic [tehs_pkg::TIME_W-1:0] fired_time,
    input logic                        last,
    input logic [tehs_pkg::TIME_W-1:0] current_time
);
    import tehs_pkg::*;

    // a new request is taken only with no result waiting
    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("request accepted while a result is pending");

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its time
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(current_time))
        else $error("result changed while stalled");

    // a result without a fired event ends its request
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired_valid |-> last)
        else $error("non-fired result not last");

    // an intermediate firing shows time at its deadline
    a_fire_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired_valid && !last |-> fired_time == current_time)
        else $error("intermediate firing time mismatch");

endmodule

bind timed_event_min_heap_scheduler tehs_checker u_tehs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fired_valid  (fired_valid),
    .fired_time   (fired_time),
    .last         (last),
    .current_time (current_time)
);

// File: verif/timed_event_min_heap_scheduler_tb.sv
// ---------------------------------------------------------------------------
// timed_event_min_heap_scheduler_tb
// Drives schedule, cancel, advance and clear requests into the event queue and
// checks every result against a heap predictor kept in the testbench.
// ---------------------------------------------------------------------------
module timed_event_min_heap_scheduler_tb;
    import tehs_pkg::*;

    localparam int NSLOT = MAX_EVENTS_DEF;

    typedef struct packed {
        logic              fv;
        logic [ID_W-1:0]   fe;
        logic [TIME_W-1:0] ft;
        logic              lst;
        logic [TIME_W-1:0] nt;
        logic [AMT_W-1:0]  cyc;
        logic [TIME_W-1:0] now;
    } firing_t;

    // heap predictor plus queue of pending expected firings
    class firing_board;
        logic [ID_W-1:0]   slot_id [NSLOT];
        logic [TIME_W-1:0] dline [NUM_IDS];
        bit                pend [NUM_IDS];
        int                pos [NUM_IDS];
        int                cnt;
        logic [TIME_W-1:0] now;
        firing_t           due_q[$];
        int                errors;

        function new();
            cnt = 0;
            now = '0;
            errors = 0;
            foreach (pend[i]) pend[i] = 0;
        endfunction

        function logic [TIME_W-1:0] key(int s);
            return dline[slot_id[s]];
        endfunction

        function void swp(int a, int b);
            logic [ID_W-1:0] t;
            t = slot_id[a];
            slot_id[a] = slot_id[b];
            slot_id[b] = t;
            pos[slot_id[a]] = a;
            pos[slot_id[b]] = b;
        endfunction

        function void up(int i);
            while (i > 0 && key(i) < key((i - 1) / 2)) begin
                swp(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
        endfunction

        function void down(int i);
            int s;
            forever
            begin
                s = i;
                if (2 * i + 1 < cnt && key(2 * i + 1) < key(s)) s = 2 * i + 1;
                if (2 * i + 2 < cnt && key(2 * i + 2) < key(s)) s = 2 * i + 2;
                if (s == i) break;
                swp(i, s);
                i = s;
            end
        endfunction

        function void remove_slot(int i);
            if (cnt == 0 || i >= cnt) return;
            cnt--;
            if (i == cnt) return;
            swp(i, cnt);
            if (i > 0 && key(i) < key((i - 1) / 2)) up(i);
            else down(i);
        endfunction

        function void take_out(int id);
            if (!pend[id]) return;
            remove_slot(pos[id]);
            pend[id] = 0;
        endfunction

        function void push(logic fv, logic [ID_W-1:0] fe, logic [TIME_W-1:0] ft,
                           logic lst);
            firing_t r;
            r.fv = fv; r.fe = fe; r.ft = ft; r.lst = lst;
            r.nt = (cnt > 0) ? key(0) : TIME_NONE;
            r.cyc = CYC_MAX;
            if (cnt > 0)
            begin
                if (r.nt <= now) r.cyc = '0;
                else if (r.nt - now < {33'd0, CYC_MAX}) r.cyc = AMT_W'(r.nt - now);
            end
            r.now = now;
            due_q.push_back(r);
        endfunction

        function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [AMT_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {{(TIME_W-AMT_W+1){1'b0}}, b};
            return s[TIME_W] ? TIME_NONE : s[TIME_W-1:0];
        endfunction

        // note an accepted request
        function void note_request(logic [1:0] op, logic [ID_W-1:0] id,
                                   logic [AMT_W-1:0] amt);
            logic [TIME_W-1:0] tgt, dl;
            logic [ID_W-1:0] ev;
            bit more;
            int k;
            k = 0;
            case (op)
                OP_SCHED:
                begin
                    take_out(id);
                    if (cnt < NSLOT)
                    begin
                        dline[id] = add_sat(now, amt);
                        pend[id] = 1;
                        slot_id[cnt] = id;
                        pos[id] = cnt;
                        cnt++;
                        up(cnt - 1);
                    end
                end
                OP_CANCEL: take_out(id);
                OP_CLEAR:
                begin
                    foreach (pend[i]) pend[i] = 0;
                    cnt = 0;
                    now = '0;
                end
                default:
                begin
                    tgt = add_sat(now, amt);
                    while (cnt > 0 && key(0) <= tgt)
                    begin
                        ev = slot_id[0];
                        dl = dline[ev];
                        now = dl;
                        remove_slot(0);
                        pend[ev] = 0;
                        more = cnt > 0 && key(0) <= tgt;
                        if (!more) now = tgt;
                        push(1'b1, ev, dl, !more);
                        k++;
                    end
                    now = tgt;
                end
            endcase
            if (k == 0) push(1'b0, '0, '0, 1'b1);
        endfunction

        // compare one result against the oldest expectation
        function void check_result(firing_t a);
            firing_t e;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result fe=%0d", a.fe);
                return;
            end
            e = due_q.pop_front();
            if (a !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display("exp fv=%0b fe=%0d ft=%0h l=%0b nt=%0h c=%0h now=%0h",
                             e.fv, e.fe, e.ft, e.lst, e.nt, e.cyc, e.now,
                             " | act fv=%0b fe=%0d ft=%0h l=%0b nt=%0h c=%0h now=%0h",
                             a.fv, a.fe, a.ft, a.lst, a.nt, a.cyc, a.now);
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [1:0]        operation = OP_SCHED;
    logic [ID_W-1:0]   event_id = '0;
    logic [AMT_W-1:0]  amount = '0;
    logic              out_valid;
    logic              out_stall = 0;
    logic              fired_valid;
    logic [ID_W-1:0]   fired_event;
    logic [TIME_W-1:0] fired_time;
    logic              last;
    logic [TIME_W-1:0] next_time;
    logic [AMT_W-1:0]  cycles_to_next;
    logic [TIME_W-1:0] current_time;

    firing_board board = new();
    bit idle_on = 1;
    bit hold_rx = 0;
    int stall_left = 0;

    timed_event_min_heap_scheduler u_dut (.*);

    always #6 clk = ~clk;

    // sample both handshakes at the edge
    always @(posedge clk)
    begin
        firing_t r;
        if (rst_n && in_valid && !in_stall) board.note_request(operation, event_id, amount);
        if (rst_n && out_valid && !out_stall)
        begin
            r.fv = fired_valid; r.fe = fired_event; r.ft = fired_time; r.lst = last;
            r.nt = next_time; r.cyc = cycles_to_next; r.now = current_time;
            board.check_result(r);
        end
    end

    // receiver stall: random bursts, plus one long hold-off
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 19);
        out_stall <= hold_rx || (stall_left > 0);
    end

    task automatic send(logic [1:0] op, logic [ID_W-1:0] id, logic [AMT_W-1:0] amt);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op;
        event_id <= id;
        amount <= amt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.due_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic rand_req();
        int r;
        logic [AMT_W-1:0] a;
        r = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? AMT_W'($urandom) : AMT_W'($urandom_range(0, 300));
        if (r < 50) send(OP_SCHED, ID_W'($urandom), a);
        else if (r < 68) send(OP_CANCEL, ID_W'($urandom), a);
        else if (r < 96) send(OP_ADV, ID_W'($urandom), a);
        else send(OP_CLEAR, ID_W'($urandom), a);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty advance, extremes, reschedule, cancel not pending
        send(OP_ADV, 5'd0, 31'd0);
        send(OP_CANCEL, 5'd31, 31'd0);
        send(OP_SCHED, 5'd0, CYC_MAX);
        send(OP_SCHED, 5'd31, 31'd0);
        send(OP_SCHED, 5'd7, 31'd5);
        send(OP_SCHED, 5'd7, 31'd2);
        send(OP_SCHED, 5'd9, 31'd2);
        send(OP_CANCEL, 5'd0, 31'd0);
        send(OP_ADV, 5'd0, 31'd3);
        send(OP_SCHED, 5'd1, CYC_MAX);
        send(OP_ADV, 5'd0, CYC_MAX);
        // advance time by large amounts, then a far schedule and a clear
        repeat (6) send(OP_ADV, 5'd0, CYC_MAX);
        send(OP_SCHED, 5'd3, CYC_MAX);
        send(OP_CLEAR, 5'd0, 31'd0);
        // fill the heap
        for (int i = 0; i < 32; i++) send(OP_SCHED, ID_W'(i), AMT_W'($urandom_range(0, 40)));
        drain();
        // long hold-off while sender keeps going, then scheduling while full
        fork
            begin
                hold_rx = 1;
                repeat (600) @(posedge clk);
                hold_rx = 0;
            end
        join_none
        send(OP_CANCEL, 5'd4, 31'd0);
        send(OP_SCHED, 5'd4, 31'd9);
        send(OP_SCHED, 5'd4, 31'd1);
        send(OP_ADV, 5'd0, 31'd100);
        for (int i = 0; i < 8; i++) rand_req();
        drain();
        // random part with idling
        for (int i = 0; i < 20; i++) rand_req();
        drain();
        // quiet tail with no idling
        idle_on = 0;
        for (int i = 0; i < 20; i++) rand_req();
        send(OP_ADV, 5'd0, CYC_MAX);
        drain();
        if (board.errors == 0 && board.due_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
hdl/tehs_pkg.sv
hdl/tehs_ram.sv
hdl/timed_event_min_heap_scheduler.sv
hdl/tehs_checker.sv
verif/timed_event_min_heap_scheduler_tb.sv
